// ===== src/interval_set_normalizer_top_assert.svh =====
// Assertion macros used by the interval set normalizer sequencer RTL.
`ifndef INTERVAL_SET_NORMALIZER_TOP_ASSERT_SVH
`define INTERVAL_SET_NORMALIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISN_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== src/isn_pkg.sv =====
package isn_pkg;

	localparam int DEF_MAX_INTERVALS = 16;
	localparam int DEF_VALUE_BITS    = 32;

	// emit strobe and result flags from the sequencer to the output register
	typedef struct packed {
		logic emit;
		logic set_empty;
		logic last_result;
	} emit_ctl_t;

endpackage

// ===== src/isn_store.sv =====
module isn_store #(
	parameter int DEPTH  = isn_pkg::DEF_MAX_INTERVALS,
	parameter int WIDTH  = 2 * isn_pkg::DEF_VALUE_BITS + 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import isn_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, loaded only while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/isn_seq.sv =====
`include "interval_set_normalizer_top_assert.svh"

module isn_seq #(
	parameter int MAX_INTERVALS = isn_pkg::DEF_MAX_INTERVALS,
	parameter int VALUE_BITS    = isn_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             in_empty,
	input  logic                             in_last,
	output logic                             mem_we,
	output logic [$clog2(MAX_INTERVALS)-1:0] mem_waddr,
	output logic                             mem_re,
	output logic [$clog2(MAX_INTERVALS)-1:0] mem_raddr,
	input  logic [2*VALUE_BITS+1:0]          mem_rdata,
	input  logic                             emit_ok,
	output isn_pkg::emit_ctl_t               ctl,
	output logic [VALUE_BITS-1:0]            out_lv,
	output logic [VALUE_BITS-1:0]            out_rv,
	output logic                             out_lc,
	output logic                             out_rc,
	output logic                             ovf
);
	import isn_pkg::*;

	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int VB = VALUE_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_PICK  = 5'b00100,
		ST_FLUSH = 5'b01000,
		ST_EMPTY = 5'b10000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, rank_q, addr_q;
	logic ovf_q;
	logic rd_v_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [VB-1:0] prev_lv_q;
	logic prev_lc_q;
	logic [IW-1:0] prev_idx_q;

	logic best_valid_q;
	logic [VB-1:0] best_lv_q, best_rv_q;
	logic best_lc_q, best_rc_q;
	logic [IW-1:0] best_idx_q;

	logic [VB-1:0] cur_lv_q, cur_rv_q;
	logic cur_lc_q, cur_rc_q;

	logic accept;
	logic [VB-1:0] r_lv, r_rv;
	logic r_lc, r_rc;
	logic eligible, better, touches, advance, first_pick;
	logic [CW-1:0] rank_inc;

	// ordering: left end, then closed before open, then arrival slot
	function automatic logic key_before(
		input logic [VB-1:0] a_lv, input logic a_lc, input logic [IW-1:0] a_idx,
		input logic [VB-1:0] b_lv, input logic b_lc, input logic [IW-1:0] b_idx
	);
		logic lt;
		lt = $signed(a_lv) < $signed(b_lv);
		if (a_lv != b_lv) begin
			return lt;
		end
		return {!a_lc, a_idx} < {!b_lc, b_idx};
	endfunction

	assign in_ready  = (state_q == ST_LOAD);
	assign accept    = in_valid && in_ready;
	assign mem_we    = accept && !in_empty && (count_q != MAX_CNT);
	assign mem_waddr = count_q[IW-1:0];
	assign mem_re    = (state_q == ST_SCAN) && (addr_q != count_q);
	assign mem_raddr = addr_q[IW-1:0];

	assign r_lv = mem_rdata[VB-1:0];
	assign r_lc = mem_rdata[VB];
	assign r_rv = mem_rdata[2*VB:VB+1];
	assign r_rc = mem_rdata[2*VB+1];

	assign first_pick = (rank_q == '0);
	assign rank_inc   = rank_q + CW'(1);
	assign eligible   = first_pick ||
		key_before(prev_lv_q, prev_lc_q, prev_idx_q, r_lv, r_lc, rd_idx_s1);
	assign better     = !best_valid_q ||
		key_before(r_lv, r_lc, rd_idx_s1, best_lv_q, best_lc_q, best_idx_q);

	// overlap, or meeting at a point that either side includes
	assign touches = ($signed(cur_rv_q) > $signed(best_lv_q)) ||
		((cur_rv_q == best_lv_q) && (cur_rc_q || best_lc_q));
	assign advance = first_pick || touches || emit_ok;

	always_comb begin
		ctl.emit        = 1'b0;
		ctl.set_empty   = 1'b0;
		ctl.last_result = 1'b0;
		case (state_q)
			ST_PICK: begin
				ctl.emit = !first_pick && !touches && emit_ok;
			end
			ST_FLUSH: begin
				ctl.emit        = emit_ok;
				ctl.last_result = 1'b1;
			end
			ST_EMPTY: begin
				ctl.emit        = emit_ok;
				ctl.set_empty   = 1'b1;
				ctl.last_result = 1'b1;
			end
			default: begin
				ctl.emit = 1'b0;
			end
		endcase
	end

	assign out_lv = (state_q == ST_EMPTY) ? '0 : cur_lv_q;
	assign out_rv = (state_q == ST_EMPTY) ? '0 : cur_rv_q;
	assign out_lc = (state_q == ST_EMPTY) ? 1'b0 : cur_lc_q;
	assign out_rc = (state_q == ST_EMPTY) ? 1'b0 : cur_rc_q;
	assign ovf    = ovf_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			rank_q       <= '0;
			addr_q       <= '0;
			rd_v_s1      <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!in_empty) begin
							if (count_q != MAX_CNT) begin
								count_q <= count_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (in_last) begin
							rank_q       <= '0;
							addr_q       <= '0;
							best_valid_q <= 1'b0;
							if (count_q == '0 && !mem_we) begin
								state_q <= ST_EMPTY;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						addr_q <= addr_q + CW'(1);
					end
					if (rd_v_s1 && eligible && better) begin
						best_valid_q <= 1'b1;
					end
					if (addr_q == count_q && !rd_v_s1) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (advance) begin
						rank_q       <= rank_inc;
						addr_q       <= '0;
						best_valid_q <= 1'b0;
						state_q      <= (rank_inc == count_q) ? ST_FLUSH : ST_SCAN;
					end
				end
				ST_FLUSH, ST_EMPTY: begin
					if (emit_ok) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IW-1:0];
		if (state_q == ST_SCAN && rd_v_s1 && eligible && better) begin
			best_lv_q  <= r_lv;
			best_rv_q  <= r_rv;
			best_lc_q  <= r_lc;
			best_rc_q  <= r_rc;
			best_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_PICK && advance) begin
			prev_lv_q  <= best_lv_q;
			prev_lc_q  <= best_lc_q;
			prev_idx_q <= best_idx_q;
			if (first_pick || !touches) begin
				cur_lv_q <= best_lv_q;
				cur_rv_q <= best_rv_q;
				cur_lc_q <= best_lc_q;
				cur_rc_q <= best_rc_q;
			end else if ($signed(cur_rv_q) < $signed(best_rv_q)) begin
				cur_rv_q <= best_rv_q;
				cur_rc_q <= best_rc_q;
			end else if (cur_rv_q == best_rv_q) begin
				cur_rc_q <= cur_rc_q || best_rc_q;
			end
		end
	end

	`ISN_ASSERT_IMPL(a_pick_has_best, clk, arst_n, state_q == ST_PICK, best_valid_q)
	`ISN_ASSERT_IMPL(a_scan_rank_bound, clk, arst_n, state_q == ST_SCAN, rank_q < count_q)
	`ISN_ASSERT_IMPL(a_emit_has_room, clk, arst_n, ctl.emit, emit_ok)
	`ISN_ASSERT_IMPL(a_write_below_full, clk, arst_n, mem_we, count_q < MAX_CNT)
	`ISN_ASSERT_NEXT(a_run_end_clears, clk, arst_n, ctl.emit && ctl.last_result, count_q == '0 && !ovf_q && state_q == ST_LOAD)

endmodule

// ===== src/interval_set_normalizer_top.sv =====
// Channel   Dir  tdata                                        tuser                  tlast
// s_axis    in   left_value, right_value, left_closed,        is_empty               last_item
//                right_closed (zero pad to bytes)
// m_axis    out  out_left, out_right, out_left_closed,        set_empty, overflow    last_result
//                out_right_closed (zero pad to bytes)
//
// Loading takes one item per cycle, only in the load state, into an interval store
// with separate write and read ports. After the item with tlast, each output rank
// costs one full scan of the store through its registered read port.
// m_axis holds one registered result; a result stalled there stalls the scan,
// and the next set loads while the final result still waits.
// Reset (arst_n low) empties the set and clears the overflow flag; no clearing pass.
module interval_set_normalizer_top #(
	parameter int MAX_INTERVALS = isn_pkg::DEF_MAX_INTERVALS,
	parameter int VALUE_BITS    = isn_pkg::DEF_VALUE_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// [VB-1:0] left_value, [2VB-1:VB] right_value, [2VB] left_closed, [2VB+1] right_closed
	input  logic [((2*VALUE_BITS+2+7)/8)*8-1:0]         s_axis_tdata,
	// [0] is_empty
	input  logic                                        s_axis_tuser,
	input  logic                                        s_axis_tlast,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// [VB-1:0] out_left, [2VB-1:VB] out_right, [2VB] out_left_closed, [2VB+1] out_right_closed
	output logic [((2*VALUE_BITS+2+7)/8)*8-1:0]         m_axis_tdata,
	// [0] set_empty, [1] overflow
	output logic [1:0]                                  m_axis_tuser,
	output logic                                        m_axis_tlast
);
	import isn_pkg::*;

	localparam int VB      = VALUE_BITS;
	localparam int IW      = $clog2(MAX_INTERVALS);
	localparam int ENTRY_W = 2 * VB + 2;
	localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;

	// store entry: {right_closed, right_value, left_closed, left_value}
	logic [ENTRY_W-1:0] wdata, rdata;
	logic mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;

	emit_ctl_t ctl;
	logic emit_ok;
	logic [VB-1:0] out_lv, out_rv;
	logic out_lc, out_rc, ovf;

	logic m_valid_q;
	logic [TDATA_W-1:0] m_data_q;
	logic [1:0] m_user_q;
	logic m_last_q;

	assign wdata = {s_axis_tdata[2*VB+1], s_axis_tdata[2*VB-1:VB],
		s_axis_tdata[2*VB], s_axis_tdata[VB-1:0]};

	isn_store #(
		.DEPTH (MAX_INTERVALS),
		.WIDTH (ENTRY_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	isn_seq #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.VALUE_BITS    (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_empty  (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (rdata),
		.emit_ok   (emit_ok),
		.ctl       (ctl),
		.out_lv    (out_lv),
		.out_rv    (out_rv),
		.out_lc    (out_lc),
		.out_rc    (out_rc),
		.ovf       (ovf)
	);

	// output slot is free when empty or being drained this cycle
	assign emit_ok = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_data_q <= TDATA_W'({out_rc, out_lc, out_rv, out_lv});
			m_user_q <= {ovf, ctl.set_empty};
			m_last_q <= ctl.last_result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ===== dv/isn_union_checker.sv =====
`timescale 1ns / 100ps

module isn_union_checker #(
	parameter int MAX_INTERVALS = isn_pkg::DEF_MAX_INTERVALS,
	parameter int VALUE_BITS    = isn_pkg::DEF_VALUE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	// [VB-1:0] left_value, [2VB-1:VB] right_value, [2VB] left_closed, [2VB+1] right_closed
	input  logic [((2*VALUE_BITS+2+7)/8)*8-1:0] s_axis_tdata,
	// [0] is_empty
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tlast,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [VB-1:0] out_left, [2VB-1:VB] out_right, [2VB] out_left_closed, [2VB+1] out_right_closed
	input  logic [((2*VALUE_BITS+2+7)/8)*8-1:0] m_axis_tdata,
	// [0] set_empty, [1] overflow
	input  logic [1:0]                          m_axis_tuser,
	input  logic                                m_axis_tlast,
	output int                                  failures,
	output int                                  pending
);

	localparam int VB  = VALUE_BITS;
	localparam int TDW = ((2*VALUE_BITS+2+7)/8)*8;

	typedef struct packed {
		logic [VB-1:0] lv;
		logic [VB-1:0] rv;
		logic          lc;
		logic          rc;
	} span_t;

	typedef struct packed {
		logic [VB-1:0] left;
		logic [VB-1:0] right;
		logic          left_closed;
		logic          right_closed;
		logic          set_empty;
		logic          overflow;
		logic          last_result;
	} merged_t;

	span_t   held [MAX_INTERVALS];
	int      held_count;
	logic    dropped;
	merged_t union_q [$];

	// sort key: left end, then closed before open
	function automatic logic precedes(span_t a, span_t b);
		if (a.lv != b.lv)
			return $signed(a.lv) < $signed(b.lv);
		return a.lc && !b.lc;
	endfunction

	// expected results wait here in emission order
	function automatic void append_result(merged_t r);
		union_q.insert(union_q.size(), r);
	endfunction

	task automatic absorb_interval(input logic [TDW-1:0] d, input logic empty,
			input logic last);
		span_t   s;
		span_t   sorted [MAX_INTERVALS];
		merged_t r;
		int      i;
		int      j;
		int      m;
		logic    touches;
		s.lv = d[VB-1:0];
		s.rv = d[2*VB-1:VB];
		s.lc = d[2*VB];
		s.rc = d[2*VB+1];
		if (!empty) begin
			if (held_count < MAX_INTERVALS) begin
				held[held_count] = s;
				held_count++;
			end else begin
				dropped = 1'b1;
			end
		end
		if (last) begin
			if (held_count == 0) begin
				r = '0;
				r.set_empty = 1'b1;
				r.overflow = dropped;
				r.last_result = 1'b1;
				append_result(r);
			end else begin
				// stable insertion sort
				for (i = 0; i < held_count; i++) begin
					s = held[i];
					j = i;
					while (j > 0 && precedes(s, sorted[j-1])) begin
						sorted[j] = sorted[j-1];
						j--;
					end
					sorted[j] = s;
				end
				m = 0;
				for (i = 1; i < held_count; i++) begin
					touches = ($signed(sorted[m].rv) > $signed(sorted[i].lv)) ||
						(sorted[m].rv == sorted[i].lv && (sorted[m].rc || sorted[i].lc));
					if (touches) begin
						if ($signed(sorted[m].rv) < $signed(sorted[i].rv)) begin
							sorted[m].rv = sorted[i].rv;
							sorted[m].rc = sorted[i].rc;
						end else if (sorted[m].rv == sorted[i].rv) begin
							sorted[m].rc = sorted[m].rc | sorted[i].rc;
						end
					end else begin
						m++;
						sorted[m] = sorted[i];
					end
				end
				for (i = 0; i <= m; i++) begin
					r.left = sorted[i].lv;
					r.right = sorted[i].rv;
					r.left_closed = sorted[i].lc;
					r.right_closed = sorted[i].rc;
					r.set_empty = 1'b0;
					r.overflow = dropped;
					r.last_result = (i == m);
					append_result(r);
				end
			end
			held_count = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		merged_t want;
		merged_t got;
		if (!arst_n) begin
			held_count = 0;
			dropped = 1'b0;
			union_q.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.left = m_axis_tdata[VB-1:0];
				got.right = m_axis_tdata[2*VB-1:VB];
				got.left_closed = m_axis_tdata[2*VB];
				got.right_closed = m_axis_tdata[2*VB+1];
				got.set_empty = m_axis_tuser[0];
				got.overflow = m_axis_tuser[1];
				got.last_result = m_axis_tlast;
				if (union_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: extra result l=%h r=%h lc=%b rc=%b emp=%b ovf=%b last=%b",
							$time, got.left, got.right, got.left_closed, got.right_closed,
							got.set_empty, got.overflow, got.last_result);
				end else begin
					want = union_q.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: mismatch exp l=%h r=%h lc=%b rc=%b emp=%b ovf=%b last=%b",
								$time, want.left, want.right, want.left_closed,
								want.right_closed, want.set_empty, want.overflow,
								want.last_result);
							$display("%0t:          got l=%h r=%h lc=%b rc=%b emp=%b ovf=%b last=%b",
								$time, got.left, got.right, got.left_closed,
								got.right_closed, got.set_empty, got.overflow,
								got.last_result);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_interval(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			pending = union_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int MAXN = isn_pkg::DEF_MAX_INTERVALS;
	localparam int VB   = isn_pkg::DEF_VALUE_BITS;
	localparam int TDW  = ((2*VB+2+7)/8)*8;

	// extreme endpoint codes: minus and plus infinity
	localparam logic [VB-1:0] NEG_INF = {1'b1, {(VB-1){1'b0}}};
	localparam logic [VB-1:0] POS_INF = {1'b0, {(VB-1){1'b1}}};
	localparam logic [VB-1:0] ONE     = 1 << 16;    // 1.0 in Q16.16

	// drain allowance: room for one post-tlast pass over a full store
	localparam int DRAIN_CYCLES = MAXN * (MAXN + 3) + 50;

	logic           clk;
	logic           arst_n        = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	// [VB-1:0] left_value, [2VB-1:VB] right_value, [2VB] left_closed, [2VB+1] right_closed
	logic [TDW-1:0] s_axis_tdata  = '0;
	// [0] is_empty
	logic           s_axis_tuser  = 1'b0;
	logic           s_axis_tlast  = 1'b0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	// [VB-1:0] out_left, [2VB-1:VB] out_right, [2VB] out_left_closed, [2VB+1] out_right_closed
	logic [TDW-1:0] m_axis_tdata;
	// [0] set_empty, [1] overflow
	logic [1:0]     m_axis_tuser;
	logic           m_axis_tlast;

	int failures;
	int pending;

	// percent of cycles in which each side holds off
	int tx_idle_pct = 27;
	int rx_idle_pct = 58;
	int sent_items;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	interval_set_normalizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	isn_union_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.failures     (failures),
		.pending      (pending)
	);

	// receiver backpressure, one decision per falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	// one interval item; entered and left at a falling edge
	task automatic send_item(input logic [VB-1:0] lv, input logic [VB-1:0] rv,
			input logic lc, input logic rc, input logic empty, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDW-2*VB-2){1'b0}}, rc, lc, rv, lv};
		s_axis_tuser <= empty;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// endpoints: mostly a coarse grid so intervals overlap and touch,
	// plus full-range codes and the two infinities
	function automatic logic [VB-1:0] pick_endpoint();
		case ($urandom_range(9))
			0: return NEG_INF;
			1: return POS_INF;
			2, 3: return VB'($urandom);
			default: return VB'($signed($urandom_range(40)) - 20) << 14;
		endcase
	endfunction

	task automatic send_random_set();
		int            size;
		int            k;
		logic [VB-1:0] lv;
		logic [VB-1:0] rv;
		// mostly within capacity, sometimes exactly full or past it
		case ($urandom_range(9))
			0: size = MAXN + $urandom_range(1, 4);
			1: size = MAXN;
			default: size = $urandom_range(1, 10);
		endcase
		for (k = 0; k < size; k++) begin
			lv = pick_endpoint();
			// well-formed most of the time, degenerate otherwise
			if ($urandom_range(9) < 8)
				rv = lv + (VB'($urandom_range(8)) << 14);
			else
				rv = pick_endpoint();
			send_item(lv, rv, 1'($urandom_range(1)), 1'($urandom_range(1)),
				($urandom_range(11) == 0), (k == size - 1));
		end
	endtask

	initial begin
		int k;
		int phase;
		sent_items = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing but an empty interval: empty union
		send_item(ONE, ONE, 1'b1, 1'b1, 1'b1, 1'b1);
		// whole line, both ends at infinity
		send_item(NEG_INF, POS_INF, 1'b1, 1'b1, 1'b0, 1'b1);
		// [0,1) and [1,2]: meet at a closed point, merge
		send_item('0, ONE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_item(ONE, 2*ONE, 1'b1, 1'b1, 1'b0, 1'b1);
		// (0,1) and (1,2): meet at an open point, stay apart
		send_item('0, ONE, 1'b0, 1'b0, 1'b0, 1'b0);
		send_item(ONE, 2*ONE, 1'b0, 1'b0, 1'b0, 1'b1);
		// tie on left end (open arrives first), reversed interval, open point
		send_item(5*ONE, 7*ONE, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(5*ONE, 6*ONE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_item(10*ONE, 3*ONE, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(4*ONE, 4*ONE, 1'b0, 1'b0, 1'b0, 1'b1);
		// one more than the store holds, the dropped one carrying tlast
		for (k = 0; k <= MAXN; k++)
			send_item(VB'(k) * 3 * ONE, VB'(k) * 3 * ONE + ONE, k[0], k[1], 1'b0, (k == MAXN));

		// random sets in three backpressure phases
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 58;
				end
				1: begin
					tx_idle_pct = 58;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			k = sent_items;
			while (sent_items - k < 100)
				send_random_set();
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for one more full pass
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("interval_set_normalizer_top test passed");
		else
			$display("interval_set_normalizer_top test failed");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("interval_set_normalizer_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/isn_pkg.sv
src/isn_store.sv
src/isn_seq.sv
src/interval_set_normalizer_top.sv
dv/isn_union_checker.sv
dv/testbench.sv
